FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

FILE: sv/cef_pkg.sv
package cef_pkg;

	localparam int unsigned KIND_W    = 5;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned FILL_W    = 7;
	localparam int unsigned MASK_W    = 32;
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 80;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] PS_APPEND  = 2'd0;
	localparam logic [1:0] PS_REPLACE = 2'd1;
	localparam logic [1:0] PS_DROP    = 2'd2;
	localparam logic [1:0] PS_NONE    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} cef_state_t;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic set_repl;
		logic finish;
	} cef_ctl_t;

	typedef struct packed {
		logic in_pop;
		logic in_coal;
		logic occ_zero;
		logic match;
		logic scan_done;
		logic out_free;
	} cef_sts_t;

endpackage

FILE: sv/cef_ctrl.sv
module cef_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  cef_pkg::cef_sts_t   sts,
	output cef_pkg::cef_ctl_t   ctl
);
	import cef_pkg::*;

	cef_state_t state_q;
	cef_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (!sts.in_pop && sts.in_coal && !sts.occ_zero) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.match || sts.scan_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		ctl.load     = 1'b0;
		ctl.scan_en  = 1'b0;
		ctl.set_repl = 1'b0;
		ctl.finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			ST_SCAN: begin
				ctl.scan_en  = 1'b1;
				ctl.set_repl = sts.match;
			end
			ST_FIN: begin
				ctl.finish = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/cef_dp.sv
`include "assert_macros.svh"

module cef_dp #(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned KIND_BITS = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cef_pkg::MASK_W-1:0]         cfg_wdata,
	input  logic [cef_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cef_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [cef_pkg::OUT_USER_W-1:0]     m_tuser,
	input  cef_pkg::cef_ctl_t                  ctl,
	output cef_pkg::cef_sts_t                  sts
);
	import cef_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned OW = $clog2(DEPTH + 1);
	localparam int unsigned KW = (KIND_BITS < KIND_W) ? KIND_BITS : KIND_W;
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC  = OW'(DEPTH);

	logic [KW-1:0]        kmem [DEPTH];
	logic [PAYLOAD_W-1:0] pmem [DEPTH];

	logic [MASK_W-1:0]    mask_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [PW-1:0]        wr_ptr_q;
	logic [OW-1:0]        occ_q;
	logic                 pop_q;
	logic [KW-1:0]        kind_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic                 repl_q;
	logic [PW-1:0]        scan_ptr_q;
	logic [OW-1:0]        cnt_q;
	logic                 cmp_vld_s1;
	logic [PW-1:0]        cmp_ptr_s1;
	logic [KW-1:0]        kind_rd_q;
	logic [PAYLOAD_W-1:0] pay_rd_q;

	logic [KW-1:0]        in_kind;
	logic                 issue;
	logic                 rd_en;
	logic [PW-1:0]        rd_addr;
	logic                 commit;
	logic                 has_ev;
	logic                 full;
	logic                 app_we;
	logic                 pay_we;
	logic [PW-1:0]        pay_waddr;
	logic [1:0]           status;
	logic [OW-1:0]        occ_nxt;
	logic [KIND_W-1:0]    res_kind;
	logic [PAYLOAD_W-1:0] res_pay;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	assign in_kind = s_tdata[KW-1:0];
	assign issue   = ctl.scan_en && (cnt_q != occ_q);
	assign rd_en   = ctl.load || issue;
	assign rd_addr = issue ? scan_ptr_q : rd_ptr_q;
	assign commit  = ctl.finish && sts.out_free;
	assign full    = (occ_q == FULL_OCC);
	assign has_ev  = pop_q && (occ_q != '0);
	assign app_we  = commit && !pop_q && !repl_q && !full;
	assign pay_we  = app_we || ctl.set_repl;
	assign pay_waddr = ctl.set_repl ? cmp_ptr_s1 : wr_ptr_q;

	assign sts.in_pop    = (s_tuser == CMD_POP);
	assign sts.in_coal   = mask_q[in_kind];
	assign sts.occ_zero  = (occ_q == '0);
	assign sts.match     = cmp_vld_s1 && (kind_rd_q == kind_q);
	assign sts.scan_done = !cmp_vld_s1 && (cnt_q == occ_q);
	assign sts.out_free  = !m_tvalid || m_tready;

	always_comb begin
		occ_nxt  = occ_q;
		res_kind = '0;
		res_pay  = '0;
		if (pop_q) begin
			status = PS_NONE;
			if (has_ev) begin
				occ_nxt  = occ_q - 1'b1;
				res_kind = KIND_W'(kind_rd_q);
				res_pay  = pay_rd_q;
			end
		end else if (repl_q) begin
			status = PS_REPLACE;
		end else if (full) begin
			status = PS_DROP;
		end else begin
			status  = PS_APPEND;
			occ_nxt = occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (app_we) begin
			kmem[wr_ptr_q] <= kind_q;
		end
		if (pay_we) begin
			pmem[pay_waddr] <= pay_q;
		end
		if (rd_en) begin
			kind_rd_q <= kmem[rd_addr];
			pay_rd_q  <= pmem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			occ_q    <= '0;
			repl_q   <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (ctl.load) begin
				repl_q <= 1'b0;
			end else if (ctl.set_repl) begin
				repl_q <= 1'b1;
			end
			cmp_vld_s1 <= issue;
			if (commit) begin
				occ_q <= occ_nxt;
				if (has_ev) begin
					rd_ptr_q <= adv(rd_ptr_q);
				end
				if (app_we) begin
					wr_ptr_q <= adv(wr_ptr_q);
				end
			end
			if (commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pop_q      <= s_tuser;
			kind_q     <= in_kind;
			pay_q      <= s_tdata[KIND_W +: PAYLOAD_W];
			scan_ptr_q <= rd_ptr_q;
			cnt_q      <= '0;
		end else if (issue) begin
			scan_ptr_q <= adv(scan_ptr_q);
			cnt_q      <= cnt_q + 1'b1;
		end
		if (issue) begin
			cmp_ptr_s1 <= scan_ptr_q;
		end
		if (commit) begin
			m_tdata <= {{(OUT_DATA_W - KIND_W - PAYLOAD_W - FILL_W){1'b0}},
				FILL_W'(occ_nxt), res_pay, res_kind};
			m_tuser <= {status, has_ev};
		end
	end

	`ASSERT_NEVER(a_occ_bound, occ_q > FULL_OCC, "occupancy above depth")
	`ASSERT_CLK(a_empty_ptrs, (occ_q == '0) |-> (rd_ptr_q == wr_ptr_q),
		"empty queue with unequal pointers")
	`ASSERT_CLK(a_repl_push, ctl.set_repl |-> (!pop_q && cmp_vld_s1 && !repl_q),
		"replace outside a push scan")
	`ASSERT_CLK(a_scan_limit, issue |-> (cnt_q < occ_q), "scan ran past the queued entries")

endmodule

FILE: sv/coalescing_event_fifo_core.sv
// A pop, a plain push, a push of a non-coalesced kind or a push to an empty queue goes from
// acceptance straight to finish; a coalescing push first scans the queue one entry a cycle.
// Only one request is in flight; s_tready is high only between requests, in idle, so a new
// request waits until the last one, with any coalescing scan, has finished.
// The result waits in an output register; a stalled m_tready holds the next request at finish.
// Reset (arst_n low): queue empty, pointers zero, coalescing mask zero; no memory clearing.
module coalescing_event_fifo_core #(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned KIND_BITS = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cef_pkg::MASK_W-1:0]         cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// event_kind [4:0], event_payload [68:5], zero pad [71:69]
	input  logic [cef_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_kind [4:0], out_payload [68:5], fill_level [75:69], zero pad [79:76]
	output logic [cef_pkg::OUT_DATA_W-1:0]     m_tdata,
	// pop_hit [0], push_status [2:1]
	output logic [cef_pkg::OUT_USER_W-1:0]     m_tuser
);
	import cef_pkg::*;

	cef_ctl_t ctl;
	cef_sts_t sts;

	cef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cef_dp #(
		.DEPTH     (DEPTH),
		.KIND_BITS (KIND_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule
